[hdl/prf_pkg.sv]
package prf_pkg;

  // Field and register widths fixed by the interface.
  localparam int WORD_W    = 32;
  localparam int ITER_W    = 16;
  localparam int TOL_W     = 31;
  localparam int DEG_W     = 3;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd2;

  // Register reset values.
  localparam logic [TOL_W-1:0]  RST_TOLERANCE = 31'd1;
  localparam logic [ITER_W-1:0] RST_LIMIT     = 16'd10000;

  // Request operations.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_FLAT      = 2'd2;

  // Scale for the percent relative step.
  localparam logic [6:0] PERCENT = 7'd100;

  // Datapath command codes.
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_LOAD    = 4'd1;
  localparam logic [3:0] CMD_START   = 4'd2;
  localparam logic [3:0] CMD_INIT_P  = 4'd3;
  localparam logic [3:0] CMD_MUL     = 4'd4;
  localparam logic [3:0] CMD_ADD     = 4'd5;
  localparam logic [3:0] CMD_INIT_D  = 4'd6;
  localparam logic [3:0] CMD_DIV_N   = 4'd7;
  localparam logic [3:0] CMD_UPDATE  = 4'd8;
  localparam logic [3:0] CMD_PCT     = 4'd9;
  localparam logic [3:0] CMD_DIV_P   = 4'd10;
  localparam logic [3:0] CMD_ADVANCE = 4'd11;
  localparam logic [3:0] CMD_EMIT    = 4'd12;

  typedef struct packed {
    logic [3:0]        op;
    logic              deriv;
    logic [IDX_W-1:0]  idx;
    logic [1:0]        status;
    logic [ITER_W-1:0] used;
  } prf_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  deg;
    logic [ITER_W-1:0] limit;
    logic              flat;
    logic              conv;
    logic              x1_zero;
    logic              div_done;
  } prf_stat_t;

endpackage

[hdl/prf_divider.sv]
module prf_divider #(
  parameter int DW = 56
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quot_r;
  logic [31:0]   rem_r;
  logic [31:0]   div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [32:0]   trial;
  logic          fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, quot_r[DW-1]};
  assign fits  = trial >= {1'b0, div_r};

  // Control of the bit-serial iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= fits ? 32'(trial - {1'b0, div_r}) : trial[31:0];
      quot_r <= {quot_r[DW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[hdl/prf_datapath.sv]
module prf_datapath #(
  parameter int MAX_DEGREE = 7,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [prf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prf_pkg::TOL_W-1:0]           cfg_data,
  input  logic [prf_pkg::DEG_W-1:0]           in_coef_idx,
  input  logic signed [prf_pkg::WORD_W-1:0]   in_coef_val,
  input  logic signed [prf_pkg::WORD_W-1:0]   in_guess,
  input  prf_pkg::prf_cmd_t                   cmd,
  output prf_pkg::prf_stat_t                  stat,
  output logic [1:0]                          out_status,
  output logic [prf_pkg::WORD_W-1:0]          out_root,
  output logic [prf_pkg::ITER_W-1:0]          out_used
);

  import prf_pkg::*;

  localparam int AW = (MAX_DEGREE < 1) ? 1 : $clog2(MAX_DEGREE + 1);
  localparam int DW = 40 + FRAC_BITS;

  // Saturate a 33-bit sum to a signed word.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
    else r = v[31:0];
    return r;
  endfunction

  // Apply a sign to a magnitude and saturate to a signed word.
  function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (m > 64'h80000000) r = 32'sh80000000;
      else r = 32'(-m[31:0]);
    end else begin
      if (m > 64'h7fffffff) r = 32'sh7fffffff;
      else r = m[31:0];
    end
    return r;
  endfunction

  logic [DEG_W-1:0]         deg_r;
  logic [TOL_W-1:0]         tol_r;
  logic [ITER_W-1:0]        lim_r;
  logic signed [31:0]       coef_r [MAX_DEGREE+1];
  logic signed [31:0]       x_r, x1_r, acc_r, fx_r, addend_r;
  logic signed [63:0]       prod_r;
  logic                     neg_r;
  logic [39:0]              pct_r;
  logic [1:0]               out_status_r;
  logic [31:0]              out_root_r;
  logic [ITER_W-1:0]        out_used_r;

  logic [IDX_W-1:0]         ld_idx;
  logic [IDX_W-1:0]         deg_used;
  logic signed [31:0]       rd;
  logic signed [36:0]       sc_full;
  logic signed [31:0]       scaled;
  logic [63:0]              pmag;
  logic signed [31:0]       fm;
  logic [31:0]              amag, fxmag, x1mag;
  logic signed [32:0]       diff;
  logic [32:0]              dmag;
  logic                     div_start;
  logic [DW-1:0]            div_dividend;
  logic [31:0]              div_divisor;
  logic                     div_done;
  logic [DW-1:0]            quot;

  // Degree in use and coefficient read port.
  assign ld_idx   = IDX_W'(in_coef_idx);
  assign deg_used = (int'(deg_r) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : IDX_W'(deg_r);
  assign rd       = coef_r[cmd.idx[AW-1:0]];

  // Coefficient scaled by its power for the derivative.
  assign sc_full = $signed({1'b0, cmd.idx}) * rd;
  assign scaled  = (sc_full[36:31] != {6{sc_full[36]}}) ?
                   (sc_full[36] ? 32'sh80000000 : 32'sh7fffffff) : sc_full[31:0];

  // Fixed-point product truncated toward zero.
  assign pmag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign fm   = sat_mag(pmag >> FRAC_BITS, prod_r[63]);

  // Magnitudes and step difference.
  assign amag  = acc_r[31] ? 32'(-acc_r) : 32'(acc_r);
  assign fxmag = fx_r[31] ? 32'(-fx_r) : 32'(fx_r);
  assign x1mag = x1_r[31] ? 32'(-x1_r) : 32'(x1_r);
  assign diff  = {x1_r[31], x1_r} - {x_r[31], x_r};
  assign dmag  = diff[32] ? 33'(-diff) : 33'(diff);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= '0;
      tol_r <= RST_TOLERANCE;
      lim_r <= RST_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEGREE:    deg_r <= cfg_data[DEG_W-1:0];
        REG_TOLERANCE: tol_r <= cfg_data;
        REG_LIMIT:     lim_r <= cfg_data[ITER_W-1:0];
        default:       ;
      endcase
    end
  end

  // Coefficient store, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_DEGREE; i++) coef_r[i] <= '0;
    end else if (cmd.op == CMD_LOAD && int'(in_coef_idx) <= MAX_DEGREE) begin
      coef_r[ld_idx[AW-1:0]] <= in_coef_val;
    end
  end

  // Arithmetic registers driven by the controller's commands.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_START:   x_r <= in_guess;
      CMD_INIT_P:  acc_r <= rd;
      CMD_MUL: begin
        prod_r   <= acc_r * x_r;
        addend_r <= cmd.deriv ? scaled : rd;
      end
      CMD_ADD:     acc_r <= sat33({fm[31], fm} + {addend_r[31], addend_r});
      CMD_INIT_D: begin
        fx_r  <= acc_r;
        acc_r <= (deg_used == '0) ? 32'sd0 : scaled;
      end
      CMD_DIV_N:   neg_r <= fx_r[31] ^ acc_r[31];
      CMD_UPDATE: begin
        x1_r <= sat33({x_r[31], x_r} - 33'(sat_mag(64'(quot), neg_r)));
      end
      CMD_PCT:     pct_r <= 40'(dmag) * 40'(PERCENT);
      CMD_ADVANCE: x_r <= x1_r;
      CMD_EMIT: begin
        out_status_r <= cmd.status;
        out_root_r   <= x_r;
        out_used_r   <= cmd.used;
      end
      default: ;
    endcase
  end

  // Shared divider for the Newton quotient and the percent step.
  assign div_start    = (cmd.op == CMD_DIV_N) || (cmd.op == CMD_DIV_P);
  assign div_dividend = (cmd.op == CMD_DIV_N) ? DW'({fxmag, {FRAC_BITS{1'b0}}})
                                              : DW'({pct_r, {FRAC_BITS{1'b0}}});
  assign div_divisor  = (cmd.op == CMD_DIV_N) ? amag : x1mag;

  prf_divider #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (quot)
  );

  // Status back to the controller.
  assign stat.deg      = deg_used;
  assign stat.limit    = lim_r;
  assign stat.flat     = {1'b0, amag} <= {2'b00, tol_r};
  assign stat.conv     = quot <= DW'(tol_r);
  assign stat.x1_zero  = (x1_r == 32'sd0);
  assign stat.div_done = div_done;

  assign out_status = out_status_r;
  assign out_root   = out_root_r;
  assign out_used   = out_used_r;

endmodule

[hdl/prf_controller.sv]
module prf_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_op,
  output logic               out_tvalid,
  input  logic               out_tready,
  output prf_pkg::prf_cmd_t  cmd,
  input  prf_pkg::prf_stat_t stat
);

  import prf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INITP = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_INITD = 4'd4;
  localparam logic [3:0] S_CHKD  = 4'd5;
  localparam logic [3:0] S_DIVN  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_PCT   = 4'd8;
  localparam logic [3:0] S_DIVP  = 4'd9;
  localparam logic [3:0] S_DWAIT = 4'd10;
  localparam logic [3:0] S_CONV  = 4'd11;
  localparam logic [3:0] S_NEXT  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic              deriv_r, deriv_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [ITER_W-1:0] used_r, used_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              last_term;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign last_term  = deriv_r ? (j_r == IDX_W'(1)) : (j_r == '0);

  // Sequencer for Horner passes, division and convergence tests.
  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    deriv_nxt     = deriv_r;
    iter_nxt      = iter_r;
    used_nxt      = used_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.op        = CMD_NONE;
    cmd.deriv     = deriv_r;
    cmd.idx       = j_r;
    cmd.status    = status_r;
    cmd.used      = used_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == OP_LOAD) begin
            cmd.op = CMD_LOAD;
          end else begin
            cmd.op   = CMD_START;
            iter_nxt = ITER_W'(1);
            if (stat.limit == '0) begin
              status_nxt = ST_LIMIT;
              used_nxt   = '0;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_INITP;
            end
          end
        end
      end
      S_INITP: begin
        cmd.op    = CMD_INIT_P;
        cmd.idx   = stat.deg;
        deriv_nxt = 1'b0;
        if (stat.deg == '0) begin
          state_nxt = S_INITD;
        end else begin
          j_nxt     = stat.deg - 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = CMD_MUL;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op = CMD_ADD;
        if (last_term) begin
          state_nxt = deriv_r ? S_CHKD : S_INITD;
        end else begin
          j_nxt     = j_r - 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_INITD: begin
        cmd.op    = CMD_INIT_D;
        cmd.idx   = stat.deg;
        deriv_nxt = 1'b1;
        if (stat.deg <= IDX_W'(1)) begin
          state_nxt = S_CHKD;
        end else begin
          j_nxt     = stat.deg - 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_CHKD: begin
        if (stat.flat) begin
          status_nxt = ST_FLAT;
          used_nxt   = iter_r;
          state_nxt  = S_EMIT;
        end else begin
          cmd.op    = CMD_DIV_N;
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (stat.div_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.op    = CMD_UPDATE;
        state_nxt = S_PCT;
      end
      S_PCT: begin
        if (stat.x1_zero) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.op    = CMD_PCT;
          state_nxt = S_DIVP;
        end
      end
      S_DIVP: begin
        cmd.op    = CMD_DIV_P;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (stat.conv) begin
          cmd.op     = CMD_ADVANCE;
          status_nxt = ST_CONVERGED;
          used_nxt   = iter_r;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd.op = CMD_ADVANCE;
        if (iter_r == stat.limit) begin
          status_nxt = ST_LIMIT;
          used_nxt   = iter_r;
          state_nxt  = S_EMIT;
        end else begin
          iter_nxt  = iter_r + 1'b1;
          state_nxt = S_INITP;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = CMD_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      deriv_r     <= 1'b0;
      iter_r      <= '0;
      used_r      <= '0;
      status_r    <= ST_LIMIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
      deriv_r     <= deriv_nxt;
      iter_r      <= iter_nxt;
      used_r      <= used_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule

[hdl/polynomial_newton_root_finder.sv]
// Newton-Raphson root finder for a fixed-point polynomial of up to MAX_DEGREE.
// Input stream: in_tuser selects the request; a load writes one coefficient
// and gives no result, a solve starts from a guess and gives one result.
// Output stream: one result per solve with status, root and step count.
// Configuration: cfg_valid/cfg_index/cfg_data write degree, tolerance and
// iteration limit; cfg_ready is always high. Write only while idle.
// Each full Newton step runs the shared bit-serial divider, one quotient bit
// per cycle, twice: once for the Newton quotient and once for the percent
// step, which is skipped when the new estimate is zero.
// A step that ends on a flat derivative stops before the divider runs.
// One request is worked on at a time; in_tready is high only while idle.
// The result register holds a finished result until out_tready; a load may
// be accepted meanwhile, and a solve that finishes waits for the register.
// Reset (rst_n low, synchronous) clears the coefficient store, sets degree
// 0, tolerance 1 and iteration limit 10000, and drops out_tvalid.
module polynomial_newton_root_finder #(
  parameter int MAX_DEGREE = 7,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // coefficient_index[2:0], coefficient_value[34:3],
                                  // start_guess[66:35], zero fill
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // root[31:0], iterations_used[47:32]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [prf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prf_pkg::TOL_W-1:0]     cfg_data
);

  import prf_pkg::*;

  prf_cmd_t          cmd;
  prf_stat_t         stat;
  logic [1:0]        res_status;
  logic [31:0]       res_root;
  logic [ITER_W-1:0] res_used;

  assign cfg_ready = 1'b1;

  prf_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  prf_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_coef_idx (in_tdata[2:0]),
    .in_coef_val (in_tdata[34:3]),
    .in_guess    (in_tdata[66:35]),
    .cmd         (cmd),
    .stat        (stat),
    .out_status  (res_status),
    .out_root    (res_root),
    .out_used    (res_used)
  );

  // Pack the result fields.
  assign out_tdata = {res_used, res_root};
  assign out_tuser = res_status;

endmodule

[sim/tb_polynomial_newton_root_finder.sv]
module tb_polynomial_newton_root_finder;
  import prf_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] root;
    logic [15:0] used;
  } solve_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_SOLVE} row_kind_t;

  // One directed row: a register write, a coefficient load or a solve.
  // Solves with a known answer carry it; the rest go through the predictor.
  typedef struct packed {
    row_kind_t     kind;
    logic [2:0]    sel;
    logic [31:0]   value;
    logic          known;
    solve_result_t answer;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOL_W-1:0]     cfg_data = '0;

  polynomial_newton_root_finder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Mirror of the block's state and registers.
  int          coef_mirror [8];
  logic [2:0]  degree_q = 3'd0;
  logic [30:0] tolerance_q = RST_TOLERANCE;
  logic [15:0] limit_q = RST_LIMIT;

  solve_result_t pending_roots[$];
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  logic          hold_request = 1'b0;
  int            hold_left = 0;
  logic          answer_known = 1'b0;
  solve_result_t answer_given;

  function automatic int clamp_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int fixed_mul(int a, int b);
    longint            p;
    longint unsigned   m;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? longint'(-p) : p;
    m = m >> 16;
    return clamp_word((p < 0) ? -longint'(m) : longint'(m));
  endfunction

  function automatic int horner_value(int x);
    int d;
    int sum;
    d = int'(degree_q);
    sum = coef_mirror[d];
    for (int i = d; i > 0; i--)
      sum = clamp_word(longint'(fixed_mul(sum, x)) + longint'(coef_mirror[i-1]));
    return sum;
  endfunction

  function automatic int horner_slope(int x);
    int d;
    int sum;
    d = int'(degree_q);
    if (d == 0) return 0;
    sum = clamp_word(longint'(d) * longint'(coef_mirror[d]));
    for (int k = d - 1; k >= 1; k--)
      sum = clamp_word(longint'(fixed_mul(sum, x)) +
                       longint'(clamp_word(longint'(k) * longint'(coef_mirror[k]))));
    return sum;
  endfunction

  // Newton iteration on the mirrored polynomial.
  function automatic solve_result_t newton_solve(int guess);
    solve_result_t   r;
    int              x;
    int              fx;
    int              dfx;
    int              x1;
    longint unsigned slope_mag;
    longint unsigned num;
    longint unsigned pct;
    longint          diff;
    x = guess;
    r.status = ST_LIMIT;
    r.used = limit_q;
    for (int i = 1; i <= int'(limit_q); i++) begin
      fx = horner_value(x);
      dfx = horner_slope(x);
      slope_mag = (dfx < 0) ? longint'(-longint'(dfx)) : longint'(dfx);
      if (slope_mag <= longint'(tolerance_q)) begin
        r.status = ST_FLAT;
        r.used = i[15:0];
        break;
      end
      x1 = clamp_word(longint'(x) -
                      longint'(clamp_word((longint'(fx) * 64'sd65536) / longint'(dfx))));
      if (x1 != 0) begin
        diff = longint'(x1) - longint'(x);
        num = ((diff < 0) ? longint'(-diff) : diff) * 64'd100;
        pct = (num << 16) / ((x1 < 0) ? longint'(-longint'(x1)) : longint'(x1));
        if (pct <= longint'(tolerance_q)) begin
          x = x1;
          r.status = ST_CONVERGED;
          r.used = i[15:0];
          break;
        end
      end
      x = x1;
    end
    r.root = x;
    return r;
  endfunction

  // Requests and results seen at the rising edge.
  always @(posedge clk) begin
    solve_result_t want;
    solve_result_t got;
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser[0] == OP_LOAD)
        coef_mirror[in_tdata[2:0]] = int'(in_tdata[34:3]);
      else if (answer_known)
        pending_roots.push_back(answer_given);
      else
        pending_roots.push_back(newton_solve(int'(in_tdata[66:35])));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.root = out_tdata[31:0];
      got.used = out_tdata[47:32];
      if (pending_roots.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected: status %0d root %h steps %0d",
                 $time, got.status, got.root, got.used);
      end else begin
        want = pending_roots.pop_front();
        if (got.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.root !== want.root) begin
          mismatch_count++;
          $display("%0t: root expected %h actual %h", $time, want.root, got.root);
        end
        if (got.used !== want.used) begin
          mismatch_count++;
          $display("%0t: steps expected %0d actual %0d", $time, want.used, got.used);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom % 100) >= recv_idle_pct;
    end
  end

  task automatic send_request(logic op, logic [2:0] idx, logic [31:0] value,
                              logic [31:0] guess, logic known, solve_result_t answer);
    @(negedge clk);
    if (($urandom % 100) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tuser <= op;
    in_tdata <= {5'b0, guess, value, idx};
    answer_known <= known;
    answer_given <= answer;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
  endtask

  // Drain every outstanding result, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [30:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_DEGREE:    degree_q = data[2:0];
      REG_TOLERANCE: tolerance_q = data;
      REG_LIMIT:     limit_q = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small values near the interesting range, sometimes any word or an extreme.
  function automatic logic [31:0] pick_word();
    case ($urandom % 6)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  plan_row_t directed [$] = '{
    '{ROW_SOLVE, 3'd0, 32'h0001_2345, 1'b1, '{ST_FLAT, 32'h0001_2345, 16'd1}},
    '{ROW_CFG, REG_LIMIT, 32'd0, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h8000_0000, 1'b1, '{ST_LIMIT, 32'h8000_0000, 16'd0}},
    '{ROW_CFG, REG_LIMIT, 32'd65535, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h7fff_ffff, 1'b1, '{ST_FLAT, 32'h7fff_ffff, 16'd1}},
    '{ROW_LOAD, 3'd0, 32'hfffe_0000, 1'b0, '0},
    '{ROW_LOAD, 3'd1, 32'h0000_0000, 1'b0, '0},
    '{ROW_LOAD, 3'd2, 32'h0001_0000, 1'b0, '0},
    '{ROW_CFG, REG_DEGREE, 32'd2, 1'b0, '0},
    '{ROW_CFG, REG_TOLERANCE, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h0003_0000, 1'b1, '{ST_FLAT, 32'h0003_0000, 16'd1}},
    '{ROW_CFG, REG_TOLERANCE, 32'h0000_0100, 1'b0, '0},
    '{ROW_CFG, REG_LIMIT, 32'd20, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h0001_0000, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h0000_0000, 1'b1, '{ST_FLAT, 32'h0000_0000, 16'd1}},
    '{ROW_CFG, REG_TOLERANCE, 32'd0, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h0000_0000, 1'b1, '{ST_FLAT, 32'h0000_0000, 16'd1}},
    '{ROW_LOAD, 3'd7, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_LOAD, 3'd3, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG, REG_DEGREE, 32'd7, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h8000_0000, 1'b0, '0},
    // p(x) = x jumps straight to zero, which never counts as converged.
    '{ROW_LOAD, 3'd0, 32'h0000_0000, 1'b0, '0},
    '{ROW_LOAD, 3'd1, 32'h0001_0000, 1'b0, '0},
    '{ROW_CFG, REG_DEGREE, 32'd1, 1'b0, '0},
    '{ROW_CFG, REG_LIMIT, 32'd3, 1'b0, '0},
    '{ROW_SOLVE, 3'd0, 32'h0005_0000, 1'b1, '{ST_LIMIT, 32'h0000_0000, 16'd3}}
  };

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int            sent;
    int            deg;
    logic [30:0]   tol;
    logic [15:0]   lim;
    solve_result_t none;
    none = '0;
    for (int i = 0; i < 8; i++) coef_mirror[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling.
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(directed[i].sel[CFG_IDX_W-1:0], directed[i].value[30:0]);
      end else if (directed[i].kind == ROW_LOAD) begin
        send_request(OP_LOAD, directed[i].sel, directed[i].value, $urandom, 1'b0, none);
      end else begin
        send_request(OP_SOLVE, 3'($urandom), $urandom, directed[i].value,
                     directed[i].known, directed[i].answer);
      end
    end

    // Random part in batches, each under fresh register settings.
    for (int b = 0; b < 11; b++) begin
      wait_idle();
      if (b < 4) begin
        send_idle_pct = 38; recv_idle_pct = 60;
      end else if (b < 8) begin
        send_idle_pct = 60; recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      deg = (b == 0) ? 7 : (b == 1) ? 0 : $urandom_range(0, 7);
      case ($urandom % 5)
        0: tol = 31'd0;
        1: tol = 31'd1;
        2: tol = 31'h7fff_ffff;
        3: tol = 31'($urandom >> 1);
        default: tol = 31'($urandom_range(2, 16'h4000));
      endcase
      if (b == 1) tol = 31'd0;
      // Long limits only where every solve stops at its first step.
      if (deg == 0)
        lim = $urandom_range(0, 1) ? 16'd65535 : 16'($urandom);
      else
        lim = ($urandom % 10 == 0) ? 16'd30 : 16'($urandom_range(0, 8));
      write_register(REG_DEGREE, 31'(deg));
      write_register(REG_TOLERANCE, tol);
      write_register(REG_LIMIT, 31'(lim));
      if (b == 5) hold_request = 1'b1;
      sent = 0;
      while (sent < 100) begin
        if ($urandom % 10 < 7) begin
          for (int k = 0; k <= deg; k++) begin
            send_request(OP_LOAD, 3'(k), pick_word(), $urandom, 1'b0, none);
            sent++;
          end
          repeat ($urandom_range(1, 3)) begin
            send_request(OP_SOLVE, 3'($urandom), $urandom, pick_word(), 1'b0, none);
            sent++;
          end
        end else begin
          send_request(1'($urandom), 3'($urandom), pick_word(), pick_word(), 1'b0, none);
          sent++;
        end
      end
    end

    wait_idle();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
hdl/prf_pkg.sv
hdl/prf_divider.sv
hdl/prf_datapath.sv
hdl/prf_controller.sv
hdl/polynomial_newton_root_finder.sv
sim/tb_polynomial_newton_root_finder.sv
